// ===== rtl/core/chunky_to_planar_words_macros.svh =====
// Assertion macros used by the top-level RTL; clock is clk, reset is rst.
`ifndef CHUNKY_TO_PLANAR_WORDS_MACROS_SVH
`define CHUNKY_TO_PLANAR_WORDS_MACROS_SVH

// same-cycle implication
`define C2P_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define C2P_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/c2p_pkg.sv =====
package c2p_pkg;

  localparam int DEF_MAX_PLANES     = 32;
  localparam int DEF_MAX_LINE_WIDTH = 4096;

  localparam int WORD_BITS   = 32;
  localparam int PLANES_W    = 6;
  localparam int WIDTH_W     = 13;
  localparam int STRIDE_W    = 8;
  localparam int LINES_W     = 13;
  localparam int OFFSET_W    = 19;
  localparam int PAD_W       = 5;
  localparam int PIDX_W      = 5;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 2;

  localparam logic [PLANES_W-1:0] RST_PLANE_COUNT      = 6'd8;
  localparam logic [WIDTH_W-1:0]  RST_LINE_WIDTH       = 13'd320;
  localparam logic [STRIDE_W-1:0] RST_PLANE_ROW_STRIDE = 8'd10;
  localparam logic [LINES_W-1:0]  RST_LINE_COUNT       = 13'd256;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PLANE_COUNT      = 2'd0,
    REG_LINE_WIDTH       = 2'd1,
    REG_PLANE_ROW_STRIDE = 2'd2,
    REG_LINE_COUNT       = 2'd3
  } cfg_reg_t;

  // burst hand-over from the accumulator stage to the drain buffer
  typedef struct packed {
    logic                load;
    logic [PAD_W-1:0]    pad;
    logic [PLANES_W-1:0] planes;
    logic [OFFSET_W-1:0] offset;
  } burst_t;

  typedef struct packed {
    logic busy;
    logic finishing;
  } drain_status_t;

endpackage

// ===== rtl/core/c2p_accum.sv =====
module c2p_accum #(
  parameter int MAX_PLANES     = c2p_pkg::DEF_MAX_PLANES,
  parameter int MAX_LINE_WIDTH = c2p_pkg::DEF_MAX_LINE_WIDTH
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   accept,
  input  logic [c2p_pkg::WORD_BITS-1:0]          pixel_value,
  input  logic [c2p_pkg::PLANES_W-1:0]           plane_count,
  input  logic [c2p_pkg::WIDTH_W-1:0]            line_width,
  input  logic [c2p_pkg::STRIDE_W-1:0]           plane_row_stride,
  input  logic [c2p_pkg::LINES_W-1:0]            line_count,
  output logic                                   trigger,
  output c2p_pkg::burst_t                        burst,
  output logic [MAX_PLANES-1:0][c2p_pkg::WORD_BITS-1:0] words
);

  localparam int COL_W  = $clog2(MAX_LINE_WIDTH + 1);
  localparam int CMP_W  = (COL_W > c2p_pkg::WIDTH_W) ? COL_W : c2p_pkg::WIDTH_W;
  localparam int CWORD_W = $clog2(MAX_LINE_WIDTH / c2p_pkg::WORD_BITS + 1);

  logic [MAX_PLANES-1:0][c2p_pkg::WORD_BITS-1:0] accum;
  logic [c2p_pkg::PAD_W-1:0]    bit_fill;
  logic [COL_W-1:0]             pixel_column;
  logic [CWORD_W-1:0]           column_word;
  logic [c2p_pkg::OFFSET_W-1:0] row_base;
  logic [c2p_pkg::LINES_W-1:0]  line_index;

  logic [c2p_pkg::PLANES_W-1:0] planes_eff;
  logic [CMP_W-1:0]             width_raw;
  logic [CMP_W-1:0]             width_eff;
  logic [c2p_pkg::LINES_W-1:0]  lines_eff;
  logic [COL_W-1:0]             col_inc;
  logic [c2p_pkg::LINES_W-1:0]  line_inc;
  logic                         word_full;
  logic                         line_end;

  always_comb begin
    if (plane_count == '0) begin
      planes_eff = c2p_pkg::PLANES_W'(1);
    end else if (plane_count > c2p_pkg::PLANES_W'(MAX_PLANES)) begin
      planes_eff = c2p_pkg::PLANES_W'(MAX_PLANES);
    end else begin
      planes_eff = plane_count;
    end
    width_raw = (line_width == '0) ? CMP_W'(1) : CMP_W'(line_width);
    width_eff = (width_raw > CMP_W'(MAX_LINE_WIDTH)) ? CMP_W'(MAX_LINE_WIDTH) : width_raw;
    lines_eff = (line_count == '0) ? c2p_pkg::LINES_W'(1) : line_count;
    col_inc   = pixel_column + COL_W'(1);
    line_inc  = line_index + c2p_pkg::LINES_W'(1);
    word_full = (bit_fill == '1);
    line_end  = CMP_W'(col_inc) >= width_eff;
    trigger   = word_full || line_end;
  end

  // new plane words with this pixel shifted in; unused planes take zeros
  always_comb begin
    for (int p = 0; p < MAX_PLANES; p++) begin
      words[p] = {accum[p][c2p_pkg::WORD_BITS-2:0],
                  pixel_value[p] & (c2p_pkg::PLANES_W'(p) < planes_eff)};
    end
  end

  always_comb begin
    burst.load   = accept && trigger;
    burst.pad    = ~bit_fill;
    burst.planes = planes_eff;
    burst.offset = row_base + c2p_pkg::OFFSET_W'(column_word);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accum        <= '0;
      bit_fill     <= '0;
      pixel_column <= '0;
      column_word  <= '0;
      row_base     <= '0;
      line_index   <= '0;
    end else if (accept) begin
      if (line_end) begin
        accum        <= '0;
        bit_fill     <= '0;
        pixel_column <= '0;
        column_word  <= '0;
        if (line_inc >= lines_eff) begin
          line_index <= '0;
          row_base   <= '0;
        end else begin
          line_index <= line_inc;
          row_base   <= row_base + c2p_pkg::OFFSET_W'(plane_row_stride);
        end
      end else begin
        accum        <= words;
        bit_fill     <= bit_fill + c2p_pkg::PAD_W'(1);
        pixel_column <= col_inc;
        if (word_full) begin
          column_word <= column_word + CWORD_W'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/core/c2p_drain.sv =====
module c2p_drain #(
  parameter int MAX_PLANES = c2p_pkg::DEF_MAX_PLANES
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  c2p_pkg::burst_t                        burst,
  input  logic [MAX_PLANES-1:0][c2p_pkg::WORD_BITS-1:0] words,
  output c2p_pkg::drain_status_t                 status,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [c2p_pkg::WORD_BITS-1:0]          plane_word,
  output logic [c2p_pkg::PIDX_W-1:0]             plane_index,
  output logic [c2p_pkg::OFFSET_W-1:0]           word_offset,
  output logic                                   last_plane
);

  localparam int IDX_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;

  logic [MAX_PLANES-1:0][c2p_pkg::WORD_BITS-1:0] word_buf;
  logic [c2p_pkg::PAD_W-1:0]    pad_buf;
  logic [c2p_pkg::PLANES_W-1:0] planes_buf;
  logic [c2p_pkg::OFFSET_W-1:0] offset_buf;
  logic [IDX_W-1:0]             idx;
  logic                         busy;
  logic                         move;
  logic                         idx_last;

  assign idx_last = (c2p_pkg::PLANES_W'(idx) == planes_buf - c2p_pkg::PLANES_W'(1));
  assign move     = busy && (!out_valid || !out_stall);

  always_comb begin
    status.busy      = busy;
    status.finishing = move && idx_last;
  end

  // buffer: loaded whole from the accumulators, drained one word a cycle while out_stall allows
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (burst.load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (move) begin
      if (idx_last) begin
        busy <= 1'b0;
      end
      idx <= idx + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (burst.load) begin
      word_buf   <= words;
      pad_buf    <= burst.pad;
      planes_buf <= burst.planes;
      offset_buf <= burst.offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      plane_word  <= word_buf[idx] << pad_buf;
      plane_index <= c2p_pkg::PIDX_W'(idx);
      word_offset <= offset_buf;
      last_plane  <= idx_last;
    end
  end

endmodule

// ===== rtl/core/chunky_to_planar_words.sv =====
// channel  | dir | valid     | stall     | payload
// ---------+-----+-----------+-----------+---------------------------------------------
// pixel in | in  | in_valid  | in_stall  | pixel_value
// words    | out | out_valid | out_stall | plane_word, plane_index, word_offset, last_plane
// config   | in  | cfg_write | -         | cfg_index, cfg_data
//
// One pixel a cycle while in_stall is low; a burst of N plane words, with N the plane
// count, leaves a buffer one word a cycle while out_stall is low. A pixel that closes
// a word or a line waits only while the previous burst is still in the buffer.
// rst is synchronous, clears all counters and accumulators; config reloads defaults.
`include "chunky_to_planar_words_macros.svh"

module chunky_to_planar_words #(
  parameter int MAX_PLANES     = c2p_pkg::DEF_MAX_PLANES,
  parameter int MAX_LINE_WIDTH = c2p_pkg::DEF_MAX_LINE_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [c2p_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [c2p_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [c2p_pkg::WORD_BITS-1:0]    pixel_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [c2p_pkg::WORD_BITS-1:0]    plane_word,
  output logic [c2p_pkg::PIDX_W-1:0]       plane_index,
  output logic [c2p_pkg::OFFSET_W-1:0]     word_offset,
  output logic                             last_plane
);

  logic [c2p_pkg::PLANES_W-1:0] plane_count;
  logic [c2p_pkg::WIDTH_W-1:0]  line_width;
  logic [c2p_pkg::STRIDE_W-1:0] plane_row_stride;
  logic [c2p_pkg::LINES_W-1:0]  line_count;

  logic                   accept;
  logic                   trigger;
  c2p_pkg::burst_t        burst;
  c2p_pkg::drain_status_t status;
  logic [MAX_PLANES-1:0][c2p_pkg::WORD_BITS-1:0] words;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_count      <= c2p_pkg::RST_PLANE_COUNT;
      line_width       <= c2p_pkg::RST_LINE_WIDTH;
      plane_row_stride <= c2p_pkg::RST_PLANE_ROW_STRIDE;
      line_count       <= c2p_pkg::RST_LINE_COUNT;
    end else if (cfg_write) begin
      case (c2p_pkg::cfg_reg_t'(cfg_index))
        c2p_pkg::REG_PLANE_COUNT:      plane_count      <= c2p_pkg::PLANES_W'(cfg_data);
        c2p_pkg::REG_LINE_WIDTH:       line_width       <= cfg_data;
        c2p_pkg::REG_PLANE_ROW_STRIDE: plane_row_stride <= c2p_pkg::STRIDE_W'(cfg_data);
        c2p_pkg::REG_LINE_COUNT:       line_count       <= cfg_data;
        default: ;
      endcase
    end
  end

  // hold a word- or line-closing pixel while the buffer still holds a burst
  assign in_stall = trigger && status.busy && !status.finishing;
  assign accept   = in_valid && !in_stall;

  c2p_accum #(
    .MAX_PLANES     (MAX_PLANES),
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_accum (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .pixel_value      (pixel_value),
    .plane_count      (plane_count),
    .line_width       (line_width),
    .plane_row_stride (plane_row_stride),
    .line_count       (line_count),
    .trigger          (trigger),
    .burst            (burst),
    .words            (words)
  );

  c2p_drain #(
    .MAX_PLANES (MAX_PLANES)
  ) u_drain (
    .clk         (clk),
    .rst         (rst),
    .burst       (burst),
    .words       (words),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .plane_word  (plane_word),
    .plane_index (plane_index),
    .word_offset (word_offset),
    .last_plane  (last_plane)
  );

  `C2P_ASSERT_NOW(a_no_overwrite, burst.load, !status.busy || status.finishing, "burst overwrites a buffer still draining")
  `C2P_ASSERT_NEXT(a_load_busy, burst.load, status.busy, "buffer not busy after a load")
  `C2P_ASSERT_NEXT(a_burst_gapless, out_valid && !out_stall && !last_plane, out_valid, "gap inside a burst")

endmodule
